// ===== design/fosp_pkg.sv =====
package fosp_pkg;

  localparam int ObjW   = 24;
  localparam int CamW   = 32;
  localparam int MagW   = 32;
  localparam int SumW   = 66;
  localparam int RootW  = 33;
  localparam int FracW  = 8;
  localparam int NumW   = 56;
  localparam int DenW   = 33;
  localparam int QuoW   = 32;
  localparam int Lanes  = 4;
  localparam int ScaleLane = 3;

  localparam logic [31:0] ScaleOne = 32'h0001_0000;
  localparam logic [31:0] ScaleMax = 32'hFFFF_FFFF;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_DIST_LIMIT = 2'd0,
    REG_RADIUS     = 2'd1,
    REG_SCALE_NUM  = 2'd2,
    REG_SCALE_GAIN = 2'd3
  } cfg_reg_e;

  // per-item data carried beside the length computation
  typedef struct packed {
    logic [2:0][CamW-1:0] obj;
    logic [2:0][CamW-1:0] cam;
    logic [2:0][MagW-1:0] mag;
    logic [2:0]           neg;
  } front_side_t;

  // one divider lane: partial remainder, dividend bits (quotient shifts in), divisor
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [DenW-1:0] den;
  } div_lane_t;

  // per-item data carried beside the dividers
  typedef struct packed {
    logic [2:0][CamW-1:0] base;
    logic [2:0]           neg;
    logic                 zero_len;
    logic                 zero_int;
    logic                 near;
  } div_side_t;

  typedef struct packed {
    logic [2:0][CamW-1:0] place;
    logic [31:0]          scale;
    logic                 near;
  } res_t;

endpackage

// ===== design/fosp_front.sv =====
module fosp_front
  import fosp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][ObjW-1:0] obj_i,
  input  logic [2:0][CamW-1:0] cam_i,
  output logic                 valid_o,
  output logic [SumW-1:0]      sum_o,
  output front_side_t          side_o
);

  logic [2:0]           valid_q;
  front_side_t          s1_q, s2_q, s3_q, s1_d;
  logic [2:0][63:0]     sq_q, sq_d;
  logic [SumW-1:0]      sum_q, sum_d;

  // form view vector and magnitudes
  always_comb begin
    logic signed [32:0] d;
    for (int i = 0; i < 3; i++) begin
      s1_d.obj[i] = {obj_i[i], {FracW{1'b0}}};
      s1_d.cam[i] = cam_i[i];
      d = $signed({obj_i[i][ObjW-1], obj_i[i], {FracW{1'b0}}})
        - $signed({cam_i[i][CamW-1], cam_i[i]});
      s1_d.neg[i] = d[32];
      s1_d.mag[i] = d[32] ? 32'(-d) : d[31:0];
    end
  end

  // square each axis
  always_comb begin
    for (int i = 0; i < 3; i++) sq_d[i] = s1_q.mag[i] * s1_q.mag[i];
  end

  // sum the squares
  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      s2_q  <= s1_q;
      sq_q  <= sq_d;
      s3_q  <= s2_q;
      sum_q <= sum_d;
    end
  end

  assign valid_o = valid_q[2];
  assign sum_o   = sum_q;
  assign side_o  = s3_q;

endmodule

// ===== design/fosp_sqrt.sv =====
module fosp_sqrt
  import fosp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SumW-1:0]  rad_i,
  input  front_side_t      side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output front_side_t      side_o
);

  // stage k reads index k and writes index k+1
  logic        [RootW:0]           v;
  logic        [RootW:0][SumW-1:0] rad;
  logic        [RootW:0][34:0]     rem;
  logic        [RootW:0][RootW-1:0] root;
  front_side_t [RootW:0]           side;

  assign v[0]    = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [36:0]      rem2, trial;
    logic             ge;
    logic [34:0]      rem_d;
    logic [RootW-1:0] root_d;
    logic             valid_q;
    logic [SumW-1:0]  rad_q;
    logic [34:0]      rem_q;
    logic [RootW-1:0] root_q;
    front_side_t      side_q;

    // bring down two bits and try the next root bit
    always_comb begin
      rem2   = {rem[k], rad[k][SumW-1 -: 2]};
      trial  = 37'({root[k], 2'b01});
      ge     = rem2 >= trial;
      rem_d  = ge ? 35'(rem2 - trial) : rem2[34:0];
      root_d = {root[k][RootW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q  <= {rad[k][SumW-3:0], 2'b00};
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= side[k];
      end
    end

    assign v[k+1]    = valid_q;
    assign rad[k+1]  = rad_q;
    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign side[k+1] = side_q;
  end

  assign valid_o = v[RootW];
  assign root_o  = root[RootW];
  assign side_o  = side[RootW];

endmodule

// ===== design/fosp_div.sv =====
module fosp_div
  import fosp_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [Lanes-1:0][NumW-1:0] num_i,
  input  logic [Lanes-1:0][DenW-1:0] den_i,
  input  div_side_t                 side_i,
  output logic                      valid_o,
  output logic [Lanes-1:0][QuoW-1:0] quo_o,
  output div_side_t                 side_o
);

  logic      [QuoW:0]                 v;
  div_lane_t [QuoW:0][Lanes-1:0]      ln;
  div_side_t [QuoW:0]                 side;

  // every dividend is below its divisor shifted up by the quotient width, when the divisor is nonzero
  for (genvar l = 0; l < Lanes; l++) begin : g_lane_in
    assign ln[0][l].rem = DenW'(num_i[l][NumW-1:QuoW]);
    assign ln[0][l].low = num_i[l][QuoW-1:0];
    assign ln[0][l].den = den_i[l];
  end
  assign v[0]    = valid_i;
  assign side[0] = side_i;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    div_lane_t [Lanes-1:0] lane_d;
    div_lane_t [Lanes-1:0] lane_q;
    div_side_t             side_q;
    logic                  valid_q;

    // one quotient bit per lane, shifted in where the dividend bit left
    always_comb begin
      logic [DenW:0] rem2;
      logic          ge;
      for (int l = 0; l < Lanes; l++) begin
        rem2 = {ln[k][l].rem, ln[k][l].low[QuoW-1]};
        ge   = rem2 >= {1'b0, ln[k][l].den};
        lane_d[l].rem = ge ? DenW'(rem2 - {1'b0, ln[k][l].den}) : rem2[DenW-1:0];
        lane_d[l].low = {ln[k][l].low[QuoW-2:0], ge};
        lane_d[l].den = ln[k][l].den;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lane_q <= lane_d;
        side_q <= side[k];
      end
    end

    assign v[k+1]    = valid_q;
    assign ln[k+1]   = lane_q;
    assign side[k+1] = side_q;
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) quo_o[l] = ln[QuoW][l].low;
  end
  assign valid_o = v[QuoW];
  assign side_o  = side[QuoW];

endmodule

// ===== design/fosp_skid.sv =====
module fosp_skid
  import fosp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  // upstream advances only while the spare slot is empty
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= valid_i;
      end
    end else if (valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (valid_i && !skid_valid_q) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

// ===== design/far_object_sphere_placement_top.sv =====
// Far-object impostor placement.
// Slave stream takes one object per beat: tdata holds the object position
// (integer units) and the camera position (Q23.8). The master stream returns
// one beat per object: the drawn position (Q23.8, saturated) and the drawing
// scale (Q16.16) in tdata, and in tuser a flag that is high when the object
// is drawn in place and low when it is pushed onto the impostor sphere.
// The view length comes from a 33-stage square root, one root bit per
// stage; position offsets and scale come from four 32-stage divider lanes,
// one quotient bit per stage. A beat passes the front, root, multiply,
// divide, finish and output registers in that order. One beat is accepted
// every cycle while the output keeps flowing. The user must write
// configuration through cfg_we_i / cfg_index_i / cfg_data_i only while no
// beat is in flight; the block does not enforce this. Reset empties the
// pipeline and loads the default registers (limit 1, radius 1.0, numerator
// 1.0, gain 1.0). When the receiver stalls, the pipeline keeps moving until
// the output register and one spare slot are full, then s_axis_tready_o
// drops and the whole pipeline holds; nothing is lost or repeated.
module far_object_sphere_placement_top
  import fosp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // obj_x, obj_y, obj_z (24 each), cam_x, cam_y, cam_z (32 each)
  input  logic [167:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // place_x, place_y, place_z, draw_scale (32 each)
  output logic [127:0] m_axis_tdata_o,
  // is_near
  output logic         m_axis_tuser_o
);

  logic [23:0] dist_limit_q, radius_q, scale_num_q;
  logic [31:0] scale_gain_q;

  // hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_limit_q <= 24'd1;
      radius_q     <= 24'd256;
      scale_num_q  <= 24'd256;
      scale_gain_q <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DIST_LIMIT: dist_limit_q <= cfg_data_i[23:0];
        REG_RADIUS:     radius_q     <= cfg_data_i[23:0];
        REG_SCALE_NUM:  scale_num_q  <= cfg_data_i[23:0];
        REG_SCALE_GAIN: scale_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic [2:0][ObjW-1:0] obj_in;
  logic [2:0][CamW-1:0] cam_in;

  assign s_axis_tready_o = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      obj_in[i] = s_axis_tdata_i[i*ObjW +: ObjW];
      cam_in[i] = s_axis_tdata_i[3*ObjW + i*CamW +: CamW];
    end
  end

  logic            fr_valid;
  logic [SumW-1:0] fr_sum;
  front_side_t     fr_side;

  fosp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .obj_i   (obj_in),
    .cam_i   (cam_in),
    .valid_o (fr_valid),
    .sum_o   (fr_sum),
    .side_o  (fr_side)
  );

  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  front_side_t      sq_side;

  fosp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_sum),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // decide near or far, form dividends and divisors
  logic [RootW-FracW-1:0]        len_int;
  logic                          near;
  logic [47:0]                   rn_prod;
  logic [Lanes-1:0][NumW-1:0]    num_d, num_q;
  logic [Lanes-1:0][DenW-1:0]    den_d, den_q;
  div_side_t                     ds_d, ds_q;
  logic                          pm_valid_q;

  assign len_int = sq_root[RootW-1:FracW];
  assign near    = len_int < {1'b0, dist_limit_q};
  assign rn_prod = radius_q * scale_num_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i]      = sq_side.mag[i] * radius_q;
      den_d[i]      = sq_root;
      ds_d.base[i]  = near ? sq_side.obj[i] : sq_side.cam[i];
      ds_d.neg[i]   = sq_side.neg[i];
    end
    num_d[ScaleLane] = NumW'(rn_prod[47:16]);
    den_d[ScaleLane] = DenW'(len_int);
    ds_d.zero_len    = sq_root == '0;
    ds_d.zero_int    = len_int == '0;
    ds_d.near        = near;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_valid_q <= 1'b0;
    end else if (en) begin
      pm_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d;
      den_q <= den_d;
      ds_q  <= ds_d;
    end
  end

  logic                       dv_valid;
  logic [Lanes-1:0][QuoW-1:0] dv_quo;
  div_side_t                  dv_side;

  fosp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pm_valid_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (ds_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // add offsets with saturation, multiply scale by gain
  logic [2:0][CamW-1:0] place_d, place_q;
  logic [63:0]          gain_prod_d, gain_prod_q;
  logic                 e1_valid_q, e1_near_q, e1_zero_int_q;

  always_comb begin
    logic signed [33:0] off, sum;
    for (int i = 0; i < 3; i++) begin
      off = (dv_side.near || dv_side.zero_len) ? 34'sd0 : $signed({2'b00, dv_quo[i]});
      if (dv_side.neg[i]) off = -off;
      sum = $signed({{2{dv_side.base[i][CamW-1]}}, dv_side.base[i]}) + off;
      if (sum > 34'sd2147483647)       place_d[i] = 32'h7FFF_FFFF;
      else if (sum < -34'sd2147483648) place_d[i] = 32'h8000_0000;
      else                             place_d[i] = sum[31:0];
    end
    gain_prod_d = dv_quo[ScaleLane] * scale_gain_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_valid_q <= 1'b0;
    end else if (en) begin
      e1_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      place_q       <= place_d;
      gain_prod_q   <= gain_prod_d;
      e1_near_q     <= dv_side.near;
      e1_zero_int_q <= dv_side.zero_int;
    end
  end

  // pick final scale
  res_t res_d, res_q;
  logic e2_valid_q;

  always_comb begin
    res_d.place = place_q;
    res_d.near  = e1_near_q;
    if (e1_near_q)                       res_d.scale = ScaleOne;
    else if (e1_zero_int_q)              res_d.scale = ScaleMax;
    else if (gain_prod_q[63:32] != '0)   res_d.scale = ScaleMax;
    else                                 res_d.scale = gain_prod_q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_valid_q <= 1'b0;
    end else if (en) begin
      e2_valid_q <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  res_t out_res;

  fosp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e2_valid_q && en),
    .data_i  (res_q),
    .ready_o (en),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  assign m_axis_tdata_o = {out_res.scale, out_res.place[2], out_res.place[1], out_res.place[0]};
  assign m_axis_tuser_o = out_res.near;

endmodule

// ===== tb/far_object_sphere_placement_top_tb.sv =====
module far_object_sphere_placement_top_tb
  import fosp_pkg::*;
;

  localparam int PipeLat   = 72;
  localparam int RandItems = 1850;
  localparam int WdogLimit = 20000;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        scale;
    logic               near;
  } placement_t;

  // one row of the directed table; chk marks a hand-written expectation
  typedef struct {
    logic signed [23:0] ox, oy, oz;
    logic signed [31:0] cx, cy, cz;
    bit                 chk;
    placement_t         want;
  } obj_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // obj_x, obj_y, obj_z (24 each), cam_x, cam_y, cam_z (32 each)
  logic [167:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // place_x, place_y, place_z, draw_scale (32 each)
  logic [127:0] m_axis_tdata_o;
  // is_near
  logic         m_axis_tuser_o;

  far_object_sphere_placement_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // placement registers as the block should hold them
  logic [23:0] near_limit;
  logic [23:0] radius_q8;
  logic [23:0] scale_num_q8;
  logic [31:0] gain_q16;

  placement_t pending_q[$];
  int  n_fail, n_sent, n_got, n_far, n_near, idle_cycles;
  bit  calm;

  // floor square root of a 66-bit sum, restoring bit by bit
  function automatic logic [35:0] floor_root(logic [65:0] s);
    logic [35:0] r;
    logic [35:0] c;
    logic [71:0] sq;
    r = '0;
    for (int b = 35; b >= 0; b--) begin
      c = r | (36'd1 << b);
      sq = c * c;
      if (sq <= {6'd0, s}) r = c;
    end
    return r;
  endfunction

  function automatic placement_t place_object(logic signed [23:0] ox, logic signed [23:0] oy,
                                              logic signed [23:0] oz, logic signed [31:0] cx,
                                              logic signed [31:0] cy, logic signed [31:0] cz);
    placement_t p;
    logic signed [63:0] obj[3], cam[3], dv[3], pl[3], off;
    logic [63:0]  mag;
    logic [65:0]  sum;
    logic [35:0]  len;
    logic [27:0]  len_int;
    logic [63:0]  k;
    logic [127:0] prod;
    obj[0] = 64'(ox) * 256; obj[1] = 64'(oy) * 256; obj[2] = 64'(oz) * 256;
    cam[0] = 64'(cx); cam[1] = 64'(cy); cam[2] = 64'(cz);
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = obj[i] - cam[i];
      mag = dv[i] < 0 ? -dv[i] : dv[i];
      sum += 66'(mag) * 66'(mag);
    end
    len = floor_root(sum);
    len_int = len[35:8];
    p.near = ({8'd0, len_int} < {12'd0, near_limit});
    if (p.near) begin
      for (int i = 0; i < 3; i++) pl[i] = obj[i];
      p.scale = ScaleOne;
    end else begin
      for (int i = 0; i < 3; i++) begin
        off = 0;
        if (len != 0) begin
          mag = dv[i] < 0 ? -dv[i] : dv[i];
          mag = (mag * radius_q8) / len;
          off = dv[i] < 0 ? -$signed(mag) : $signed(mag);
        end
        pl[i] = cam[i] + off;
        if (pl[i] > 64'sh7FFF_FFFF) pl[i] = 64'sh7FFF_FFFF;
        if (pl[i] < -64'sh8000_0000) pl[i] = -64'sh8000_0000;
      end
      if (len_int == 0) p.scale = ScaleMax;
      else begin
        k = (64'(radius_q8) * 64'(scale_num_q8)) / (64'(len_int) << 16);
        prod = 128'(k) * 128'(gain_q16);
        p.scale = prod > 128'hFFFF_FFFF ? ScaleMax : prod[31:0];
      end
    end
    p.px = pl[0][31:0]; p.py = pl[1][31:0]; p.pz = pl[2][31:0];
    return p;
  endfunction

  // write one register at a clock edge and track it
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DIST_LIMIT: near_limit   = val[23:0];
      REG_RADIUS:     radius_q8    = val[23:0];
      REG_SCALE_NUM:  scale_num_q8 = val[23:0];
      REG_SCALE_GAIN: gain_q16     = val;
      default: ;
    endcase
  endtask

  // hold a beat until the block takes it; expectation queued on acceptance
  task automatic send_object(obj_row_t r);
    placement_t p;
    p = r.chk ? r.want : place_object(r.ox, r.oy, r.oz, r.cx, r.cy, r.cz);
    while (!calm && $urandom_range(99) < 38) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {r.cz, r.cy, r.cx, r.oz, r.oy, r.ox};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_q.push_back(p);
    n_sent++;
  endtask

  // drop the input, drain, then let the pipeline empty before touching registers
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 8) @(posedge clk_i);
  endtask

  function automatic obj_row_t rand_row(int mode);
    obj_row_t r;
    r.chk = 1'b0;
    r.want = '0;
    r.ox = 24'($urandom); r.oy = 24'($urandom); r.oz = 24'($urandom);
    case (mode)
      0: begin r.cx = $urandom; r.cy = $urandom; r.cz = $urandom; end
      // camera close to the object so the near branch and small lengths occur
      1: begin
        r.cx = 32'(r.ox) * 256 + $signed($urandom_range(8191)) - 4096;
        r.cy = 32'(r.oy) * 256 + $signed($urandom_range(8191)) - 4096;
        r.cz = 32'(r.oz) * 256 + $signed($urandom_range(8191)) - 4096;
      end
      default: begin
        r.ox = 24'($signed($urandom_range(2000)) - 1000);
        r.oy = 24'($signed($urandom_range(2000)) - 1000);
        r.oz = 24'($signed($urandom_range(2000)) - 1000);
        r.cx = $signed($urandom_range(200000)) - 100000;
        r.cy = $signed($urandom_range(200000)) - 100000;
        r.cz = $signed($urandom_range(200000)) - 100000;
      end
    endcase
    return r;
  endfunction

  // receiver stalls and result check
  always @(posedge clk_i) begin
    placement_t got, exp_p;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tdata_o[95:64],
               m_axis_tdata_o[127:96], m_axis_tuser_o};
        n_got++;
        if (pending_q.size() == 0) begin
          $error("beat with no expectation waiting");
          n_fail++;
        end else begin
          exp_p = pending_q.pop_front();
          if (got.near) n_near++; else n_far++;
          if (got.px !== exp_p.px) begin
            $error("place_x exp %h got %h", exp_p.px, got.px); n_fail++; end
          if (got.py !== exp_p.py) begin
            $error("place_y exp %h got %h", exp_p.py, got.py); n_fail++; end
          if (got.pz !== exp_p.pz) begin
            $error("place_z exp %h got %h", exp_p.pz, got.pz); n_fail++; end
          if (got.scale !== exp_p.scale) begin
            $error("draw_scale exp %h got %h", exp_p.scale, got.scale); n_fail++; end
          if (got.near !== exp_p.near) begin
            $error("is_near exp %b got %b", exp_p.near, got.near); n_fail++; end
        end
      end
      m_axis_tready_i <= calm || ($urandom_range(99) >= 38);
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    obj_row_t dir_tab[$];
    obj_row_t r;
    int mode;
    n_sent = 0;
    calm = 1'b0;
    near_limit = 24'd1; radius_q8 = 24'd256; scale_num_q8 = 24'd256; gain_q16 = 32'd65536;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows: defaults after reset, extremes, zero length
    dir_tab.push_back('{0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0, ScaleOne, 1'b1}});
    dir_tab.push_back('{1, 0, 0, 0, 0, 0, 1'b1, '{256, 0, 0, 32'h0001_0000, 1'b0}});
    dir_tab.push_back('{0, 0, 0, 128, 0, 0, 1'b1, '{0, 0, 0, ScaleOne, 1'b1}});
    dir_tab.push_back('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                        32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, '0});
    dir_tab.push_back('{-24'sh800000, -24'sh800000, -24'sh800000,
                        32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '0});
    dir_tab.push_back('{-24'sh800000, 24'sh7FFFFF, 0, 0, -1, 32'sh7FFFFFFF, 1'b0, '0});
    dir_tab.push_back('{3, -4, 0, 0, 0, 0, 1'b0, '0});
    dir_tab.push_back('{-1, -1, -1, -1, -1, -1, 1'b0, '0});
    foreach (dir_tab[i]) send_object(dir_tab[i]);
    wait_drained();

    // zero limit: zero length goes far and lands on the camera
    write_reg(REG_DIST_LIMIT, 32'd0);
    write_reg(REG_RADIUS, 32'hFFFFFF);
    write_reg(REG_SCALE_NUM, 32'hFFFFFF);
    write_reg(REG_SCALE_GAIN, 32'hFFFFFFFF);
    send_object('{5, -5, 7, 1280, -1280, 1792, 1'b1, '{1280, -1280, 1792, ScaleMax, 1'b0}});
    send_object('{0, 0, 0, 100, 0, 0, 1'b0, '0});
    send_object('{-24'sh800000, 24'sh7FFFFF, -24'sh800000,
                  32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0, '0});
    send_object('{1000, 2000, -3000, 0, 0, 0, 1'b0, '0});
    wait_drained();
    write_reg(REG_DIST_LIMIT, 32'hFFFFFF);
    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_SCALE_NUM, 32'd0);
    write_reg(REG_SCALE_GAIN, 32'd0);
    send_object('{24'sh7FFFFF, 0, 0, 0, 0, 0, 1'b1,
                  '{32'sh7FFFFF00, 0, 0, ScaleOne, 1'b1}});
    send_object('{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, '0});
    wait_drained();

    // random phases, each under fresh register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_DIST_LIMIT, ph == 0 ? 32'd1 : $urandom_range(1 << $urandom_range(23)));
      write_reg(REG_RADIUS, $urandom >> $urandom_range(31));
      write_reg(REG_SCALE_NUM, $urandom >> $urandom_range(31));
      write_reg(REG_SCALE_GAIN, $urandom >> $urandom_range(31));
      calm = (ph == 3);
      for (int n = 0; n < RandItems / 8; n++) begin
        mode = $urandom_range(2);
        r = rand_row(mode);
        send_object(r);
      end
      wait_drained();
    end
    calm = 1'b0;

    $display("Sent %0d objects, received %0d placements", n_sent, n_got);
    $display("Projected onto sphere: %0d, drawn in place: %0d", n_far, n_near);
    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
